// ===== rtl/csrb_pkg.sv =====
package csrb_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_WR,
    ST_NODE_RD,
    ST_NODE_WR,
    ST_EDGE_RD,
    ST_CUR_RD,
    ST_CUR_WR,
    ST_FETCH,
    ST_FETCH_OUT
  } state_e;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_FETCH  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_OFFSET = 2'd1;
  localparam logic [1:0] KIND_NEIGH  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_READING = 2'd3;

  localparam int unsigned IdW   = 10;
  localparam int unsigned ValW  = 13;
  localparam int unsigned NnW   = 11;

endpackage

// ===== rtl/csrb_ram.sv =====
module csrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/edge_list_to_csr_builder_top.sv =====
// Edge list to CSR builder. Each input transfer is a load, a fetch, a clear or an unused
// opcode and yields exactly one output transfer. The first fetch after loading also runs
// the build: a prefix sum over the nodes (degree read, then start and cursor write),
// then a scatter over the stored edges (edge read, cursor read, then neighbour and cursor
// write), each step bound by the registered read of the node and edge memories.
// After reset and after each clear, the degree memory is swept to zero while no input
// transfer is taken.
module edge_list_to_csr_builder_top #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // edge_source [9:0], edge_target [19:10]
  input  logic [1:0]  s_axis_tuser,  // opcode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // word_value [12:0], status [14:13]
  output logic [1:0]  m_axis_tuser,  // word_kind [1:0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned IW  = (NCW > EW) ? NCW : EW;
  localparam int unsigned RPW = $clog2(MAX_NODES + MAX_EDGES + 1);

  csrb_pkg::state_e state_q, state_d;

  logic [csrb_pkg::NnW-1:0] nn_q;
  logic [EW-1:0]  ecnt_q, ecnt_d;
  logic [RPW-1:0] rpos_q, rpos_d;
  logic           built_q, built_d;
  logic           clr_ack_q, clr_ack_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic [EW-1:0]  run_q, run_d;
  logic [csrb_pkg::IdW-1:0] src_q, src_d, dst_q, dst_d;

  logic                      out_vld_q, out_vld_d;
  logic [1:0]                kind_q, kind_d, stat_q, stat_d;
  logic [csrb_pkg::ValW-1:0] val_q, val_d;
  logic                      last_q, last_d;

  logic [csrb_pkg::IdW-1:0] in_src, in_dst;
  logic [1:0]     in_op;
  logic           in_fire;
  logic [NCW-1:0] n_eff;
  logic [31:0]    nn32;
  logic [RPW-1:0] total;
  logic           rd_node;

  logic          deg_we, cur_we, start_we, est_we, nl_we;
  logic [NW-1:0] deg_waddr, deg_raddr, cur_waddr, cur_raddr, start_raddr;
  logic [EW-1:0] deg_wdata, cur_wdata, deg_rdata, cur_rdata, start_rdata;
  logic [AW-1:0] est_raddr, nl_waddr, nl_raddr;
  logic [csrb_pkg::IdW-1:0] esrc_rdata, edst_rdata, nl_rdata;

  assign in_op   = s_axis_tuser;
  assign in_src  = s_axis_tdata[9:0];
  assign in_dst  = s_axis_tdata[19:10];
  assign s_axis_tready = (state_q == csrb_pkg::ST_IDLE) && !out_vld_q;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  assign nn32  = 32'(nn_q);
  assign n_eff = (nn_q == '0) ? NCW'(1) :
                 (nn32 > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(nn_q);
  assign total = RPW'(n_eff) + RPW'(ecnt_q);
  assign rd_node = 32'(rpos_q) < 32'(n_eff);

  assign pready = 1'b1;
  assign prdata = 32'(nn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nn_q <= csrb_pkg::NnW'(1024);
    end else if (psel && penable && pwrite && pready && paddr == 1'b0 &&
                 ecnt_q == '0 && !built_q) begin
      nn_q <= pwdata[csrb_pkg::NnW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      csrb_pkg::ST_CLEAR: begin
        if (idx_q == IW'(MAX_NODES - 1)) state_d = csrb_pkg::ST_IDLE;
      end
      csrb_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            csrb_pkg::OP_LOAD: begin
              if (!built_q && 32'(in_src) < 32'(n_eff) && 32'(in_dst) < 32'(n_eff) &&
                  32'(ecnt_q) < MAX_EDGES) begin
                state_d = csrb_pkg::ST_LOAD_WR;
              end
            end
            csrb_pkg::OP_FETCH: begin
              state_d = built_q ? csrb_pkg::ST_FETCH : csrb_pkg::ST_NODE_RD;
            end
            csrb_pkg::OP_CLEAR: state_d = csrb_pkg::ST_CLEAR;
            default: state_d = csrb_pkg::ST_IDLE;
          endcase
        end
      end
      csrb_pkg::ST_LOAD_WR: state_d = csrb_pkg::ST_IDLE;
      csrb_pkg::ST_NODE_RD: state_d = csrb_pkg::ST_NODE_WR;
      csrb_pkg::ST_NODE_WR: begin
        if (32'(idx_q) + 1 < 32'(n_eff)) begin
          state_d = csrb_pkg::ST_NODE_RD;
        end else if (ecnt_q == '0) begin
          state_d = csrb_pkg::ST_FETCH;
        end else begin
          state_d = csrb_pkg::ST_EDGE_RD;
        end
      end
      csrb_pkg::ST_EDGE_RD: state_d = csrb_pkg::ST_CUR_RD;
      csrb_pkg::ST_CUR_RD:  state_d = csrb_pkg::ST_CUR_WR;
      csrb_pkg::ST_CUR_WR: begin
        state_d = (32'(idx_q) + 1 < 32'(ecnt_q)) ? csrb_pkg::ST_EDGE_RD
                                                   : csrb_pkg::ST_FETCH;
      end
      csrb_pkg::ST_FETCH: begin
        state_d = (rpos_q >= total) ? csrb_pkg::ST_IDLE : csrb_pkg::ST_FETCH_OUT;
      end
      csrb_pkg::ST_FETCH_OUT: state_d = csrb_pkg::ST_IDLE;
      default: state_d = csrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ecnt_d    = ecnt_q;
    rpos_d    = rpos_q;
    built_d   = built_q;
    clr_ack_d = clr_ack_q;
    idx_d     = idx_q;
    run_d     = run_q;
    src_d     = src_q;
    dst_d     = dst_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    kind_d    = kind_q;
    val_d     = val_q;
    stat_d    = stat_q;
    last_d    = last_q;
    deg_we    = 1'b0;
    deg_waddr = NW'(idx_q);
    deg_wdata = '0;
    deg_raddr = NW'(in_src);
    cur_we    = 1'b0;
    cur_waddr = NW'(idx_q);
    cur_wdata = run_q;
    cur_raddr = NW'(esrc_rdata);
    start_we  = 1'b0;
    start_raddr = NW'(rpos_q);
    est_we    = 1'b0;
    est_raddr = AW'(idx_q);
    nl_we     = 1'b0;
    nl_waddr  = AW'(cur_rdata);
    nl_raddr  = AW'(rpos_q - RPW'(n_eff));
    case (state_q)
      csrb_pkg::ST_CLEAR: begin
        deg_we = 1'b1;
        idx_d  = idx_q + IW'(1);
        if (idx_q == IW'(MAX_NODES - 1)) begin
          idx_d     = '0;
          clr_ack_d = 1'b0;
          if (clr_ack_q) begin
            out_vld_d = 1'b1;
            kind_d    = csrb_pkg::KIND_ACK;
            val_d     = '0;
            stat_d    = csrb_pkg::STAT_OK;
            last_d    = 1'b0;
          end
        end
      end
      csrb_pkg::ST_IDLE: begin
        if (in_fire) begin
          kind_d = csrb_pkg::KIND_ACK;
          val_d  = '0;
          stat_d = csrb_pkg::STAT_OK;
          last_d = 1'b0;
          src_d  = in_src;
          idx_d  = '0;
          run_d  = '0;
          case (in_op)
            csrb_pkg::OP_LOAD: begin
              out_vld_d = 1'b1;
              if (built_q) begin
                stat_d = csrb_pkg::STAT_READING;
              end else if (32'(in_src) >= 32'(n_eff) || 32'(in_dst) >= 32'(n_eff)) begin
                stat_d = csrb_pkg::STAT_RANGE;
              end else if (32'(ecnt_q) >= MAX_EDGES) begin
                stat_d = csrb_pkg::STAT_FULL;
              end else begin
                out_vld_d = 1'b0;
                est_we    = 1'b1;
              end
            end
            csrb_pkg::OP_FETCH: ;
            csrb_pkg::OP_CLEAR: begin
              clr_ack_d = 1'b1;
              ecnt_d    = '0;
              rpos_d    = '0;
              built_d   = 1'b0;
            end
            default: out_vld_d = 1'b1;
          endcase
        end
      end
      csrb_pkg::ST_LOAD_WR: begin
        deg_we    = 1'b1;
        deg_waddr = NW'(src_q);
        deg_wdata = deg_rdata + EW'(1);
        ecnt_d    = ecnt_q + EW'(1);
        out_vld_d = 1'b1;
      end
      csrb_pkg::ST_NODE_RD: begin
        deg_raddr = NW'(idx_q);
      end
      csrb_pkg::ST_NODE_WR: begin
        start_we = 1'b1;
        cur_we   = 1'b1;
        run_d    = run_q + deg_rdata;
        idx_d    = idx_q + IW'(1);
        if (!(32'(idx_q) + 1 < 32'(n_eff))) begin
          idx_d = '0;
          if (ecnt_q == '0) built_d = 1'b1;
        end
      end
      csrb_pkg::ST_EDGE_RD: ;
      csrb_pkg::ST_CUR_RD: begin
        src_d = esrc_rdata;
        dst_d = edst_rdata;
      end
      csrb_pkg::ST_CUR_WR: begin
        nl_we     = 1'b1;
        cur_we    = 1'b1;
        cur_waddr = NW'(src_q);
        cur_wdata = cur_rdata + EW'(1);
        idx_d     = idx_q + IW'(1);
        if (!(32'(idx_q) + 1 < 32'(ecnt_q))) built_d = 1'b1;
      end
      csrb_pkg::ST_FETCH: begin
        if (rpos_q >= total) begin
          out_vld_d = 1'b1;
          kind_d    = csrb_pkg::KIND_NONE;
        end
      end
      csrb_pkg::ST_FETCH_OUT: begin
        out_vld_d = 1'b1;
        kind_d = rd_node ? csrb_pkg::KIND_OFFSET : csrb_pkg::KIND_NEIGH;
        val_d  = rd_node ? csrb_pkg::ValW'(start_rdata) : csrb_pkg::ValW'(nl_rdata);
        rpos_d = rpos_q + RPW'(1);
        last_d = (rpos_q + RPW'(1)) == total;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= csrb_pkg::ST_CLEAR;
      ecnt_q    <= '0;
      rpos_q    <= '0;
      built_q   <= 1'b0;
      clr_ack_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ecnt_q    <= ecnt_d;
      rpos_q    <= rpos_d;
      built_q   <= built_d;
      clr_ack_q <= clr_ack_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q  <= run_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
    kind_q <= kind_d;
    val_q  <= val_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, stat_q, val_q};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

  csrb_ram #(.Width(EW), .Depth(MAX_NODES)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wdata),
    .raddr_i(deg_raddr), .rdata_o(deg_rdata)
  );

  csrb_ram #(.Width(EW), .Depth(MAX_NODES)) u_cursor (
    .clk_i, .we_i(cur_we), .waddr_i(cur_waddr), .wdata_i(cur_wdata),
    .raddr_i(cur_raddr), .rdata_o(cur_rdata)
  );

  csrb_ram #(.Width(EW), .Depth(MAX_NODES)) u_start (
    .clk_i, .we_i(start_we), .waddr_i(NW'(idx_q)), .wdata_i(run_q),
    .raddr_i(start_raddr), .rdata_o(start_rdata)
  );

  csrb_ram #(.Width(csrb_pkg::IdW), .Depth(MAX_EDGES)) u_esrc (
    .clk_i, .we_i(est_we), .waddr_i(AW'(ecnt_q)), .wdata_i(in_src),
    .raddr_i(est_raddr), .rdata_o(esrc_rdata)
  );

  csrb_ram #(.Width(csrb_pkg::IdW), .Depth(MAX_EDGES)) u_edst (
    .clk_i, .we_i(est_we), .waddr_i(AW'(ecnt_q)), .wdata_i(in_dst),
    .raddr_i(est_raddr), .rdata_o(edst_rdata)
  );

  csrb_ram #(.Width(csrb_pkg::IdW), .Depth(MAX_EDGES)) u_neigh (
    .clk_i, .we_i(nl_we), .waddr_i(nl_waddr), .wdata_i(dst_q),
    .raddr_i(nl_raddr), .rdata_o(nl_rdata)
  );

endmodule
